>>> design/mcr_pkg.sv
package mcr_pkg;

  localparam int FRAC_W   = 17;
  localparam int FRAC_SH  = 16;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 11;

  localparam int IN_DW    = 56;
  localparam int OUT_DW   = 48;
  localparam int OUT_UW   = 2;

  localparam int PIX_W    = 10;
  localparam int COL_W    = 8;
  localparam int NPOINTS  = 8;
  localparam int PT_W     = 3;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RED    = 3'd2,
    CFG_GREEN  = 3'd3,
    CFG_BLUE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } pen_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             in_frame;
    pen_t             pen;
    logic             last_of_step;
    logic             circle_done;
  } res_t;

  function automatic logic [FRAC_W-1:0] sat_frac(input logic [FRAC_W-1:0] f);
    return (f > FRAC_ONE) ? FRAC_ONE : f;
  endfunction

endpackage

>>> design/mcr_front.sv
module mcr_front import mcr_pkg::*; #(
  parameter int CW = 10
) (
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [IN_DW-1:0]    s_tdata_i,
  input  logic                s_tuser_i,
  input  logic [CW-1:0]       wm1_i,
  input  logic [CW-1:0]       hm1_i,
  input  logic                q_full_i,
  output logic                push_o,
  output logic [3*CW:0]       cmd_o
);

  localparam int PRW = FRAC_W + CW;

  logic [FRAC_W-1:0] cx_frac, cy_frac, r_frac;
  logic [PRW-1:0]    prod_cx, prod_cy, prod_r;

  assign cx_frac = sat_frac(s_tdata_i[0 +: FRAC_W]);
  assign cy_frac = sat_frac(s_tdata_i[FRAC_W +: FRAC_W]);
  assign r_frac  = sat_frac(s_tdata_i[2*FRAC_W +: FRAC_W]);

  assign prod_cx = PRW'(cx_frac) * PRW'(wm1_i);
  assign prod_cy = PRW'(cy_frac) * PRW'(hm1_i);
  assign prod_r  = PRW'(r_frac)  * PRW'(wm1_i);

  assign cmd_o = {s_tuser_i, prod_r[FRAC_SH +: CW], prod_cx[FRAC_SH +: CW],
                  prod_cy[FRAC_SH +: CW]};

  assign s_tready_o = !q_full_i;
  assign push_o     = s_tvalid_i && !q_full_i;

endmodule

>>> design/mcr_queue.sv
module mcr_queue #(
  parameter int W     = 31,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> design/mcr_back.sv
module mcr_back import mcr_pkg::*; #(
  parameter int CW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  logic [3*CW:0] q_data_i,
  output logic          pop_o,
  input  logic [CW-1:0] wm1_i,
  input  logic [CW-1:0] hm1_i,
  input  pen_t          pen_i,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output res_t          res_o
);

  localparam int PW = CW + 2;
  localparam int EW = CW + 4;
  localparam logic signed [PW-1:0] P_ONE = PW'(1);
  localparam logic signed [EW-1:0] E_ONE = EW'(1);
  localparam logic signed [EW-1:0] E_TWO = EW'(2);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [PT_W-1:0]        k_q, k_d;
  logic [CW-1:0]          cx_q, cx_d, cy_q, cy_d, r_q, r_d;
  logic signed [PW-1:0]   x_q, x_d, y_q, y_d;
  logic signed [EW-1:0]   dx_q, dx_d, dy_q, dy_d, err_q, err_d;
  logic                   busy_q, busy_d;
  logic                   out_valid_q, out_valid_d;
  res_t                   out_q, out_d;

  req_e                   kind;
  logic [CW-1:0]          r_in, cx_in, cy_in;
  logic signed [EW-1:0]   r2, e1, e_n, dx_n, dy_n;
  logic signed [PW-1:0]   x_n, y_n;
  logic                   busy_n;

  logic                   swap, xneg, yneg, in_fr;
  logic signed [PW-1:0]   a, b, cxs, cys, px, py, wm1s, hm1s;
  res_t                   pt, marker;
  logic                   out_adv;

  assign kind  = req_e'(q_data_i[3*CW]);
  assign r_in  = q_data_i[2*CW +: CW];
  assign cx_in = q_data_i[CW +: CW];
  assign cy_in = q_data_i[0 +: CW];

  always_comb begin
    r2 = $signed(EW'({r_q, 1'b0}));
    if (err_q <= 0) begin
      y_n  = y_q + P_ONE;
      e1   = err_q + dy_q;
      dy_n = dy_q + E_TWO;
    end else begin
      y_n  = y_q;
      e1   = err_q;
      dy_n = dy_q;
    end
    if (e1 > 0) begin
      x_n  = x_q - P_ONE;
      dx_n = dx_q + E_TWO;
      e_n  = e1 + dx_n - r2;
    end else begin
      x_n  = x_q;
      dx_n = dx_q;
      e_n  = e1;
    end
    busy_n = (x_n >= y_n);
  end

  always_comb begin
    swap = k_q inside {3'd1, 3'd2, 3'd5, 3'd6};
    xneg = k_q inside {3'd2, 3'd3, 3'd4, 3'd5};
    yneg = k_q inside {3'd4, 3'd5, 3'd6, 3'd7};
    a    = swap ? y_q : x_q;
    b    = swap ? x_q : y_q;
    cxs  = $signed(PW'(cx_q));
    cys  = $signed(PW'(cy_q));
    wm1s = $signed(PW'(wm1_i));
    hm1s = $signed(PW'(hm1_i));
    px   = xneg ? cxs - a : cxs + a;
    py   = yneg ? cys - b : cys + b;
    in_fr = (px >= 0) && (px <= wm1s) && (py >= 0) && (py <= hm1s);

    pt.pixel_x      = in_fr ? PIX_W'($unsigned(px)) : '0;
    pt.pixel_y      = in_fr ? PIX_W'($unsigned(py)) : '0;
    pt.in_frame     = in_fr;
    pt.pen          = pen_i;
    pt.last_of_step = (k_q == PT_W'(NPOINTS - 1));
    pt.circle_done  = !busy_n;

    marker              = '0;
    marker.last_of_step = 1'b1;
    marker.circle_done  = 1'b1;
  end

  assign out_adv = !out_valid_q || m_tready_i;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    r_d         = r_q;
    x_d         = x_q;
    y_d         = y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    err_d       = err_q;
    busy_d      = busy_q;
    out_d       = out_q;
    out_valid_d = out_adv ? 1'b0 : out_valid_q;
    pop_o       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (kind == REQ_START) begin
            pop_o  = 1'b1;
            cx_d   = cx_in;
            cy_d   = cy_in;
            r_d    = r_in;
            x_d    = $signed(PW'(r_in)) - P_ONE;
            y_d    = '0;
            dx_d   = E_ONE;
            dy_d   = E_ONE;
            err_d  = E_ONE - $signed(EW'({r_in, 1'b0}));
            busy_d = (r_in != '0);
          end else if (out_adv) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            if (busy_q) begin
              out_d   = pt;
              k_d     = k_q + 1'b1;
              state_d = ST_EMIT;
            end else begin
              out_d = marker;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_adv) begin
          out_valid_d = 1'b1;
          out_d       = pt;
          k_d         = k_q + 1'b1;
          if (k_q == PT_W'(NPOINTS - 1)) begin
            x_d     = x_n;
            y_d     = y_n;
            dx_d    = dx_n;
            dy_d    = dy_n;
            err_d   = e_n;
            busy_d  = busy_n;
            k_d     = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        k_d     = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      r_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      dx_q        <= E_ONE;
      dy_q        <= E_ONE;
      err_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      r_q         <= r_d;
      x_q         <= x_d;
      y_q         <= y_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      err_q       <= err_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign res_o      = out_q;

endmodule

>>> design/midpoint_circle_rasterizer_top.sv
// A step item passes through the command queue and the output register before its
// first point shows when the point engine is free; the next seven points follow one
// per cycle unless the output stalls, holding the single result port while the queue
// takes new items. A start item or a done marker needs only the idle state.
// Reset: asynchronous, active low; clears the command queue, the circle state and the
// output register, and loads the frame and pen registers with their defaults.
module midpoint_circle_rasterizer_top import mcr_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  // center_x_frac[16:0], center_y_frac[33:17], radius_frac[50:34], zero pad
  input  logic [IN_DW-1:0]  s_tdata_i,
  // req_type[0]
  input  logic              s_tuser_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  // pixel_x[9:0], pixel_y[19:10], red[27:20], green[35:28], blue[43:36], zero pad
  output logic [OUT_DW-1:0] m_tdata_o,
  // in_frame[0], circle_done[1]
  output logic [OUT_UW-1:0] m_tuser_o,
  output logic              m_tlast_o
);

  localparam int CW     = $clog2(MAX_DIM);
  localparam int CMD_W  = 3 * CW + 1;
  localparam int QDEPTH = 2;

  function automatic logic [CW-1:0] dim_m1(input logic [CFG_DW-1:0] v);
    logic [CFG_DW+1:0] ve;
    ve = {2'b00, v};
    if (v == '0) begin
      return '0;
    end
    if (ve > (CFG_DW + 2)'(MAX_DIM)) begin
      return CW'(MAX_DIM - 1);
    end
    return CW'(v - 1'b1);
  endfunction

  localparam logic [CW-1:0] RST_DM1 = dim_m1(CFG_DW'(256));

  logic [CW-1:0]    wm1_q, hm1_q;
  pen_t             pen_q;
  logic             q_full, q_push, q_pop, q_valid;
  logic [CMD_W-1:0] cmd_in, cmd_out;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= RST_DM1;
      hm1_q <= RST_DM1;
      pen_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_WIDTH:  wm1_q     <= dim_m1(cfg_data_i);
        CFG_HEIGHT: hm1_q     <= dim_m1(cfg_data_i);
        CFG_RED:    pen_q.red   <= cfg_data_i[COL_W-1:0];
        CFG_GREEN:  pen_q.green <= cfg_data_i[COL_W-1:0];
        CFG_BLUE:   pen_q.blue  <= cfg_data_i[COL_W-1:0];
        default: ;
      endcase
    end
  end

  mcr_front #(.CW(CW)) u_front (
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .wm1_i      (wm1_q),
    .hm1_i      (hm1_q),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (cmd_in)
  );

  mcr_queue #(.W(CMD_W), .DEPTH(QDEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  mcr_back #(.CW(CW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (cmd_out),
    .pop_o      (q_pop),
    .wm1_i      (wm1_q),
    .hm1_i      (hm1_q),
    .pen_i      (pen_q),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .res_o      (res)
  );

  assign m_tdata_o = {4'b0000, res.pen.blue, res.pen.green, res.pen.red,
                      res.pixel_y, res.pixel_x};
  assign m_tuser_o = {res.circle_done, res.in_frame};
  assign m_tlast_o = res.last_of_step;

endmodule

>>> design/mcr_checker.sv
module mcr_sva import mcr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_tvalid_o,
  input logic              m_tready_i,
  input logic [OUT_DW-1:0] m_tdata_o,
  input logic [OUT_UW-1:0] m_tuser_o,
  input logic              m_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) &&
    $stable(m_tuser_o) && $stable(m_tlast_o))
    else $error("stalled result changed");

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o[0] |-> m_tdata_o[2*PIX_W-1:0] == '0)
    else $error("clipped point carries non-zero coordinates");

  a_step_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && !m_tlast_o |=>
    m_tvalid_o && (m_tuser_o[1] == $past(m_tuser_o[1])))
    else $error("point burst broken or done flag changed within a step");

endmodule

bind midpoint_circle_rasterizer_top mcr_sva u_mcr_checker (.*);

>>> verif/mcr_checker.sv
`timescale 1ns / 100ps

module mcr_checker import mcr_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [IN_DW-1:0]  s_tdata_i,
  input  logic              s_tuser_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [OUT_DW-1:0] m_tdata_i,
  input  logic [OUT_UW-1:0] m_tuser_i,
  input  logic              m_tlast_i,
  output int                errors_o,
  output int                pending_o
);

  logic [CFG_DW-1:0] frame_w, frame_h;
  logic [COL_W-1:0]  pen_r, pen_g, pen_b;

  int centre_col, centre_row, radius;
  int major, minor, step_x, step_y, error_acc;
  bit drawing;

  res_t expected_points[$];
  res_t got, want;
  int   seen;

  function automatic int clamp_dim(input logic [CFG_DW-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int scale_frac(input logic [FRAC_W-1:0] f, input int dim);
    longint sat, span;
    sat  = (f > FRAC_ONE) ? longint'(FRAC_ONE) : longint'(f);
    span = dim - 1;
    return int'((sat * span) >> FRAC_SH);
  endfunction

  function automatic res_t plot(input int px, input int py);
    res_t p;
    int   w, h;
    bit   hit;
    w   = clamp_dim(frame_w);
    h   = clamp_dim(frame_h);
    hit = px >= 0 && px <= w - 1 && py >= 0 && py <= h - 1;
    p = '0;
    p.pixel_x   = hit ? px[PIX_W-1:0] : '0;
    p.pixel_y   = hit ? py[PIX_W-1:0] : '0;
    p.in_frame  = hit;
    p.pen.red   = pen_r;
    p.pen.green = pen_g;
    p.pen.blue  = pen_b;
    return p;
  endfunction

  task automatic trace_octants(input logic kind, input logic [IN_DW-1:0] data);
    res_t pts[NPOINTS];
    res_t marker;
    int   w, h;
    if (kind == REQ_START) begin
      w = clamp_dim(frame_w);
      h = clamp_dim(frame_h);
      radius     = scale_frac(data[50:34], w);
      centre_col = scale_frac(data[16:0], w);
      centre_row = scale_frac(data[33:17], h);
      major      = radius - 1;
      minor      = 0;
      step_x     = 1;
      step_y     = 1;
      error_acc  = 1 - 2 * radius;
      drawing    = major >= minor;
    end else if (!drawing) begin
      marker = '0;
      marker.last_of_step = 1'b1;
      marker.circle_done  = 1'b1;
      expected_points.push_back(marker);
    end else begin
      pts[0] = plot(centre_col + major, centre_row + minor);
      pts[1] = plot(centre_col + minor, centre_row + major);
      pts[2] = plot(centre_col - minor, centre_row + major);
      pts[3] = plot(centre_col - major, centre_row + minor);
      pts[4] = plot(centre_col - major, centre_row - minor);
      pts[5] = plot(centre_col - minor, centre_row - major);
      pts[6] = plot(centre_col + minor, centre_row - major);
      pts[7] = plot(centre_col + major, centre_row - minor);
      if (error_acc <= 0) begin
        minor     += 1;
        error_acc += step_y;
        step_y    += 2;
      end
      if (error_acc > 0) begin
        major     -= 1;
        step_x    += 2;
        error_acc += step_x - 2 * radius;
      end
      drawing = major >= minor;
      pts[NPOINTS-1].last_of_step = 1'b1;
      for (int k = 0; k < NPOINTS; k++) begin
        pts[k].circle_done = !drawing;
        expected_points.push_back(pts[k]);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] point %0d mismatch: %s", $time, seen, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input int actual, input int wanted);
    if (actual !== wanted) report_mismatch($sformatf("%s is %0d, want %0d", name, actual, wanted));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w    = 11'd256;
      frame_h    = 11'd256;
      pen_r      = '0;
      pen_g      = '0;
      pen_b      = '0;
      centre_col = 0;
      centre_row = 0;
      radius     = 0;
      major      = 0;
      minor      = 0;
      step_x     = 1;
      step_y     = 1;
      error_acc  = 0;
      drawing    = 1'b0;
      seen       = 0;
      errors_o   = 0;
      expected_points.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = '0;
        got.pixel_x      = m_tdata_i[9:0];
        got.pixel_y      = m_tdata_i[19:10];
        got.pen.red      = m_tdata_i[27:20];
        got.pen.green    = m_tdata_i[35:28];
        got.pen.blue     = m_tdata_i[43:36];
        got.in_frame     = m_tuser_i[0];
        got.circle_done  = m_tuser_i[1];
        got.last_of_step = m_tlast_i;
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("transfer with nothing expected (x %0d y %0d)",
                                    got.pixel_x, got.pixel_y));
        end else begin
          want = expected_points.pop_front();
          check_field("pixel_x", got.pixel_x, want.pixel_x);
          check_field("pixel_y", got.pixel_y, want.pixel_y);
          check_field("in_frame", got.in_frame, want.in_frame);
          check_field("red", got.pen.red, want.pen.red);
          check_field("green", got.pen.green, want.pen.green);
          check_field("blue", got.pen.blue, want.pen.blue);
          check_field("last_of_step", got.last_of_step, want.last_of_step);
          check_field("circle_done", got.circle_done, want.circle_done);
        end
        seen++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_WIDTH:  frame_w = cfg_data_i;
          CFG_HEIGHT: frame_h = cfg_data_i;
          CFG_RED:    pen_r   = cfg_data_i[COL_W-1:0];
          CFG_GREEN:  pen_g   = cfg_data_i[COL_W-1:0];
          CFG_BLUE:   pen_b   = cfg_data_i[COL_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) trace_octants(s_tuser_i, s_tdata_i);
    end
    pending_o = expected_points.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import mcr_pkg::*;

  localparam int LIMIT  = 2000;
  localparam int HOLD   = 300;
  localparam int SETTLE = 32;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_AW-1:0] cfg_addr_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic              s_tvalid_i;
  logic              s_tready_o;
  logic [IN_DW-1:0]  s_tdata_i;
  logic              s_tuser_i;
  logic              m_tvalid_o;
  logic              m_tready_i = 1'b0;
  logic [OUT_DW-1:0] m_tdata_o;
  logic [OUT_UW-1:0] m_tuser_o;
  logic              m_tlast_o;

  int errors, pending;
  int send_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int held      = 0;
  int quiet     = 0;

  int send_mix[4]  = '{0, 61, 0, 30};
  int stall_mix[4] = '{0, 0, 61, 30};

  midpoint_circle_rasterizer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

  mcr_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_i  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_i  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_i   (m_tdata_o),
    .m_tuser_i   (m_tuser_o),
    .m_tlast_i   (m_tlast_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // hold off for a long stretch on request, otherwise stall at random
  always @(negedge clk_i) begin
    if (hold_req) begin
      m_tready_i <= 1'b0;
      held = held + 1;
      if (held == HOLD) begin
        hold_req = 1'b0;
        held     = 0;
      end
    end else begin
      m_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet = 0;
    else quiet = quiet + 1;
    if (quiet >= LIMIT) begin
      $display("** midpoint_circle_rasterizer_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [FRAC_W-1:0] pick_centre();
    if ($urandom_range(7) == 0) return FRAC_W'($urandom);
    return FRAC_W'($urandom_range(65536));
  endfunction

  function automatic logic [CFG_DW-1:0] pick_dim();
    case ($urandom_range(7))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd1024;
      3: return 11'h7FF;
      default: return CFG_DW'($urandom_range(1, 1024));
    endcase
  endfunction

  task automatic offer(input req_e kind, input logic [FRAC_W-1:0] cx,
                       input logic [FRAC_W-1:0] cy, input logic [FRAC_W-1:0] rad);
    @(negedge clk_i);
    while ($urandom_range(99) < send_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= kind;
    s_tdata_i  <= IN_DW'({rad, cy, cx});
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic step_circle();
    offer(REQ_STEP, FRAC_W'($urandom), FRAC_W'($urandom), FRAC_W'($urandom));
  endtask

  // drop valid, drain every expected point, then let a queued start finish
  task automatic settle();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                           input logic [CFG_DW-1:0] r, input logic [CFG_DW-1:0] g,
                           input logic [CFG_DW-1:0] b);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_RED, r);
    write_reg(CFG_GREEN, g);
    write_reg(CFG_BLUE, b);
  endtask

  task automatic run_phase(input int quota);
    int sent;
    int steps;
    logic [FRAC_W-1:0] rad;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(9) == 0) begin
        step_circle();
        sent++;
      end else begin
        rad = ($urandom_range(9) == 0) ? FRAC_W'($urandom)
                                       : FRAC_W'($urandom_range(2500));
        offer(REQ_START, pick_centre(), pick_centre(), rad);
        steps = $urandom_range(1, 20);
        repeat (steps) step_circle();
        sent += steps + 1;
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_addr_i  = CFG_WIDTH;
    cfg_data_i  = '0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    s_tuser_i   = REQ_START;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: idle step, zero radius, clipped edges, saturated fractions
    offer(REQ_STEP, '0, '0, '0);
    offer(REQ_START, 17'h08000, 17'h08000, '0);
    offer(REQ_STEP, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    offer(REQ_START, '0, '0, 17'h00800);
    repeat (3) step_circle();
    offer(REQ_START, 17'h08000, 17'h08000, 17'd1300);
    repeat (5) step_circle();
    offer(REQ_START, FRAC_ONE, 17'h1FFFF, 17'h1FFFF);
    repeat (2) step_circle();
    settle();

    set_frame(11'd1024, 11'd1, 11'd255, 11'd255, 11'd255);
    offer(REQ_START, 17'h08000, '0, 17'd1300);
    repeat (3) step_circle();
    settle();

    // registers change while the circle is still open
    set_frame(11'd0, 11'h7FF, 11'h7FF, 11'd0, 11'h2AA);
    repeat (3) step_circle();
    offer(REQ_START, 17'h08000, 17'h08000, 17'd700);
    step_circle();
    settle();

    // back-pressure: fill the block, then drain completely
    set_frame(11'd1024, 11'd1024, 11'h12, 11'h34, 11'h56);
    offer(REQ_START, 17'h08000, 17'h08000, 17'h04000);
    hold_req = 1'b1;
    repeat (40) step_circle();
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      send_pct  = send_mix[ph];
      stall_pct = stall_mix[ph];
      set_frame(pick_dim(), pick_dim(), CFG_DW'($urandom), CFG_DW'($urandom),
                CFG_DW'($urandom));
      run_phase(65);
      settle();
    end

    if (errors == 0) begin
      $display("** midpoint_circle_rasterizer_top: PASSED **");
    end else begin
      $display("** midpoint_circle_rasterizer_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> midpoint_circle_rasterizer_top.f
design/mcr_pkg.sv
design/mcr_front.sv
design/mcr_queue.sv
design/mcr_back.sv
design/midpoint_circle_rasterizer_top.sv
design/mcr_checker.sv
verif/mcr_checker.sv
verif/tb.sv
